// ----- src/assert_macros.svh -----
// Assertion macros shared by the AES block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge, off while reset is low.
`define AES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("aes assertion failed");

// Antecedent implies consequent in the next cycle.
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes assertion failed");

`else

`define AES_ASSERT(lbl, clk, rst_n, prop)
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/aesbe_pkg.sv -----
// Package for the AES-128 block encryptor: byte tables, GF helpers, stage type.
`default_nettype none

package aesbe_pkg;

  localparam int unsigned BlockW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned NumRnd  = 10;
  localparam int unsigned CfgIdxW = 1;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  // Reduction byte of x^8 + x^4 + x^3 + x + 1
  localparam logic [7:0] GfPoly = 8'h1b;

  // Round constants for rounds 1 to 10
  localparam logic [7:0] RCON [NumRnd] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Forward S-box: GF(2^8) inverse followed by the affine map
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Data carried from one pipeline stage to the next
  typedef struct packed {
    logic [BlockW-1:0] state;
    logic [BlockW-1:0] rkey;
  } stage_t;

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

endpackage

`default_nettype wire

// ----- src/aesbe_round.sv -----
// One registered AES round stage: round function plus next round key.
`default_nettype none

module aesbe_round
  import aesbe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire stage_t     stage_i,
  input  wire logic [7:0] rcon_i,
  input  wire logic       last_i,
  output logic            valid_o,
  output stage_t          stage_o
);

  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];
  logic [7:0] k  [16];
  logic [7:0] nk [16];
  stage_t     stage_d;
  stage_t     stage_q;
  logic       valid_q;

  // Unpack bytes, byte 0 in the top bits
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = stage_i.state[BlockW-1-8*i -: 8];
      k[i] = stage_i.rkey[BlockW-1-8*i -: 8];
    end
  end

  // SubBytes and ShiftRows
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = sub_byte(s[4*((c+r)&3)+r]);
      end
    end
  end

  // MixColumns, skipped in the last round
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (last_i) begin
        m[4*c]   = t[4*c];
        m[4*c+1] = t[4*c+1];
        m[4*c+2] = t[4*c+2];
        m[4*c+3] = t[4*c+3];
      end else begin
        m[4*c]   = gf_dbl(t[4*c]) ^ gf_dbl(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        m[4*c+1] = t[4*c] ^ gf_dbl(t[4*c+1]) ^ gf_dbl(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
        m[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_dbl(t[4*c+2]) ^ gf_dbl(t[4*c+3]) ^ t[4*c+3];
        m[4*c+3] = gf_dbl(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ gf_dbl(t[4*c+3]);
      end
    end
  end

  // Key schedule step: rotated, substituted last word plus round constant
  always_comb begin
    nk[0] = k[0] ^ rcon_i ^ sub_byte(k[13]);
    nk[1] = k[1] ^ sub_byte(k[14]);
    nk[2] = k[2] ^ sub_byte(k[15]);
    nk[3] = k[3] ^ sub_byte(k[12]);
    for (int i = 4; i < 16; i++) begin
      nk[i] = k[i] ^ nk[i-4];
    end
  end

  // AddRoundKey with the new key; pack back
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      stage_d.state[BlockW-1-8*i -: 8] = m[i] ^ nk[i];
      stage_d.rkey[BlockW-1-8*i -: 8]  = nk[i];
    end
  end

  // Stage valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload, loaded only when a beat moves in
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- src/aes128_block_encrypt_unit.sv -----
// Top level of the pipelined AES-128 block encryptor.
`default_nettype none

// AES-128 encryption of one 128-bit block per beat. The key is written through
// the configuration port (index 0 = key bytes 0..7, index 1 = key bytes 8..15) and
// is used by blocks accepted afterwards. The datapath is eleven register stages: the
// initial AddRoundKey, then one stage per round, each with its own S-box lookups and
// its own key-schedule step, the round key travelling down the pipe with the block.
// A new block can be taken every cycle while in_stall_o is low, so throughput is one
// block per clock. Each stage has its own valid bit and holds only while the stage
// ahead is full and held, so bubbles are squeezed out when the output is stalled.

`include "assert_macros.svh"

module aes128_block_encrypt_unit
  import aesbe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [HalfW-1:0]   cfg_wdata_i,
  // plaintext channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [HalfW-1:0]   plain_high_i,
  input  wire logic [HalfW-1:0]   plain_low_i,
  // ciphertext channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [HalfW-1:0]        cipher_high_o,
  output logic [HalfW-1:0]        cipher_low_o
);

  logic [HalfW-1:0] key_high_q;
  logic [HalfW-1:0] key_low_q;

  logic   vld [NumRnd+1];
  logic   en  [NumRnd+1];
  stage_t stg [NumRnd+1];
  logic   in_acc;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeyHigh: key_high_q <= cfg_wdata_i;
        RegKeyLow:  key_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its occupant moves on
  always_comb begin
    en[NumRnd] = !vld[NumRnd] || !out_stall_i;
    for (int i = NumRnd - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall_o = !en[0];
  assign in_acc     = in_valid_i && en[0];

  // Stage 0: initial AddRoundKey
  logic   vld0_q;
  stage_t stg0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en[0]) begin
      vld0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg0_q.state <= {plain_high_i, plain_low_i} ^ {key_high_q, key_low_q};
      stg0_q.rkey  <= {key_high_q, key_low_q};
    end
  end

  assign vld[0] = vld0_q;
  assign stg[0] = stg0_q;

  // Round stages 1 to 10
  for (genvar g = 1; g <= NumRnd; g++) begin : g_round
    aesbe_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g]),
      .valid_i (vld[g-1]),
      .stage_i (stg[g-1]),
      .rcon_i  (RCON[g-1]),
      .last_i  (g == NumRnd),
      .valid_o (vld[g]),
      .stage_o (stg[g])
    );
  end

  assign out_valid_o   = vld[NumRnd];
  assign cipher_high_o = stg[NumRnd].state[BlockW-1 -: HalfW];
  assign cipher_low_o  = stg[NumRnd].state[HalfW-1:0];

  // Checks
  `AES_ASSERT_NEXT(a_acc_fills_stage0, clk_i, rst_ni, in_acc, vld[0])
  `AES_ASSERT_NEXT(a_held_stage_keeps, clk_i, rst_ni, vld[NumRnd/2] && !en[NumRnd/2], vld[NumRnd/2] && $stable(stg[NumRnd/2]))
  `AES_ASSERT(a_out_from_last_round, clk_i, rst_ni, !$rose(out_valid_o) || $past(vld[NumRnd-1]))

endmodule

`default_nettype wire
